FILE: hw/rtl/slmc_pkg.sv
// ----------------------------------------------------------------------------
// slmc_pkg: shared types and constants of the LED matrix controller
// Frame positions, marker reset values, command and result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package slmc_pkg;

    localparam int CNT_W = 5;

    localparam logic [7:0] START_MARKER_RESET = 8'h4B;
    localparam logic [7:0] STOP_MARKER_RESET  = 8'h7E;
    localparam logic [7:0] OPC_SET_LED        = 8'h01;
    localparam logic [7:0] ROW_MSB            = 8'h80;
    localparam logic [7:0] PATTERN_ALL_OFF    = 8'hFF;
    localparam logic [7:0] COLUMN_NONE        = 8'h00;
    localparam logic [7:0] COLUMN_ONE         = 8'h01;

    // Byte positions inside a frame, counted from the start marker.
    localparam logic [CNT_W-1:0] POS_START  = 5'd0;
    localparam logic [CNT_W-1:0] POS_OPCODE = 5'd2;
    localparam logic [CNT_W-1:0] POS_INDEX  = 5'd3;
    localparam logic [CNT_W-1:0] POS_ONOFF  = 5'd4;
    localparam logic [CNT_W-1:0] POS_BODY   = 5'd5;

    // Configuration register indexes.
    localparam logic [7:0] CFG_START_MARKER = 8'd0;
    localparam logic [7:0] CFG_STOP_MARKER  = 8'd1;

    // Command from the frame parser to the matrix store.
    typedef struct packed {
        logic       frame_done;
        logic       wr;
        logic [2:0] col;
        logic [2:0] row_sel;
        logic       led_on;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [7:0] store_pattern;
        logic [2:0] store_column;
        logic       store_valid;
        logic       frame_done;
        logic [7:0] row_drive;
        logic [7:0] column_drive;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/slmc_frame.sv
// ----------------------------------------------------------------------------
// slmc_frame: command frame parser
// Counts frame bytes, captures opcode, LED index and on/off value, and
// issues a matrix write when a well-formed frame closes.
// ----------------------------------------------------------------------------
`default_nettype none

module slmc_frame
    import slmc_pkg::*;
#(
    parameter int MAX_FRAME = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic       i_is_byte,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_start_marker,
    input  wire logic [7:0] i_stop_marker,
    output t_cmd            o_cmd
);

    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]       r_opcode, n_opcode;
    logic [7:0]       r_led_index, n_led_index;
    logic [7:0]       r_onoff, n_onoff;

    logic             keep;
    logic             is_stop;
    logic [CNT_W:0]   pos_inc;

    always_comb begin
        keep    = i_is_byte && !((r_byte_count == POS_START) && (i_byte != i_start_marker));
        is_stop = (i_byte == i_stop_marker);
        pos_inc = {1'b0, r_byte_count} + {{CNT_W{1'b0}}, 1'b1};

        o_cmd.frame_done = keep && is_stop;
        o_cmd.wr         = keep && is_stop && (r_byte_count >= POS_BODY)
                           && (r_opcode == OPC_SET_LED)
                           && (r_led_index[7:6] == 2'b00)
                           && (r_onoff[7:1] == 7'd0);
        o_cmd.col        = r_led_index[2:0];
        o_cmd.row_sel    = r_led_index[5:3];
        o_cmd.led_on     = r_onoff[0];

        n_byte_count = r_byte_count;
        n_opcode     = r_opcode;
        n_led_index  = r_led_index;
        n_onoff      = r_onoff;
        if (keep) begin
            if (r_byte_count == POS_OPCODE) begin
                n_opcode = i_byte;
            end else if (r_byte_count == POS_INDEX) begin
                n_led_index = i_byte;
            end else if (r_byte_count == POS_ONOFF) begin
                n_onoff = i_byte;
            end
            if (is_stop || (pos_inc >= (CNT_W+1)'(MAX_FRAME))) begin
                n_byte_count = POS_START;
            end else begin
                n_byte_count = pos_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= POS_START;
            r_opcode     <= 8'd0;
            r_led_index  <= 8'd0;
            r_onoff      <= 8'd0;
        end else if (i_advance) begin
            r_byte_count <= n_byte_count;
            r_opcode     <= n_opcode;
            r_led_index  <= n_led_index;
            r_onoff      <= n_onoff;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/slmc_matrix.sv
// ----------------------------------------------------------------------------
// slmc_matrix: row pattern store and column scanner
// Holds the eight active-low column patterns, applies LED writes and
// drives one column per scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module slmc_matrix
    import slmc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_advance,
    input  wire logic i_tick,
    input  t_cmd      i_cmd,
    output t_result   o_res
);

    logic [7:0] r_pattern [8];
    logic [2:0] r_scan_column;

    logic [2:0] rd_addr;
    logic [7:0] rd_pattern;
    logic [7:0] row_bit;
    logic [7:0] new_pattern;

    always_comb begin
        rd_addr     = i_tick ? r_scan_column : i_cmd.col;
        rd_pattern  = r_pattern[rd_addr];
        row_bit     = ROW_MSB >> i_cmd.row_sel;
        new_pattern = i_cmd.led_on ? (rd_pattern & ~row_bit) : (rd_pattern | row_bit);

        o_res = '0;
        if (i_tick) begin
            o_res.column_drive = COLUMN_ONE << r_scan_column;
            o_res.row_drive    = rd_pattern;
        end else begin
            o_res.column_drive = COLUMN_NONE;
            o_res.row_drive    = PATTERN_ALL_OFF;
            o_res.frame_done   = i_cmd.frame_done;
            if (i_cmd.wr) begin
                o_res.store_valid   = 1'b1;
                o_res.store_column  = i_cmd.col;
                o_res.store_pattern = new_pattern;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_pattern[i] <= PATTERN_ALL_OFF;
            end
            r_scan_column <= 3'd0;
        end else if (i_advance) begin
            if (i_tick) begin
                r_scan_column <= r_scan_column + 3'd1;
            end else if (i_cmd.wr) begin
                r_pattern[i_cmd.col] <= new_pattern;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/serial_framed_led_matrix_controller.sv
// ----------------------------------------------------------------------------
// serial_framed_led_matrix_controller: serial command framer and LED scanner
// Frames serial commands that set LEDs of an 8x8 active-low matrix, scans
// the matrix one column per tick and reports every pattern change.
// ----------------------------------------------------------------------------
// Each input item is either a received serial byte (tuser = 0) or a scan tick
// (tuser = 1), and produces exactly one result item. An item passes an input
// register and then a result register. A new item is taken every cycle while
// the output side keeps up; the result register and the input register each
// hold one item during a stall. Frames have the form start, length, opcode,
// led_index, onoff, ..., stop. Opcode 1 with index below 64 and onoff 0 (off)
// or 1 (on) rewrites one column pattern and reports it on the store fields.
// Marker registers are written over the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_framed_led_matrix_controller
    import slmc_pkg::*;
#(
    parameter int MAX_FRAME = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] op
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] column_drive, [15:8] row_drive,
                                             // [16] frame_done, [17] store_valid,
                                             // [20:18] store_column,
                                             // [28:21] store_pattern, [31:29] zero
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic [7:0] r_start_mk, r_stop_mk;

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       advance;
    t_cmd       cmd;
    t_result    res;

    // Load the result register when it is empty or being drained.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

    // Marker registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mk <= START_MARKER_RESET;
            r_stop_mk  <= STOP_MARKER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_start_mk <= i_cfg_data;
                CFG_STOP_MARKER:  r_stop_mk  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: hold the item until the result register can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    slmc_frame #(
        .MAX_FRAME(MAX_FRAME)
    ) u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_is_byte      (!r_in_op),
        .i_byte         (r_in_byte),
        .i_start_marker (r_start_mk),
        .i_stop_marker  (r_stop_mk),
        .o_cmd          (cmd)
    );

    slmc_matrix u_matrix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_tick    (r_in_op),
        .i_cmd     (cmd),
        .o_res     (res)
    );

    // Result register: advance on a moved item, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire
